// ----- hw/rtl/tow_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tanh overdrive package
// Shared constants, register map and the control/status types of the shaper.
// ----------------------------------------------------------------------------
package tow_pkg;

    // Default sample width and tanh table size
    localparam int TOW_SAMPLE_WIDTH    = 24;
    localparam int TOW_TANH_TABLE_SIZE = 1024;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_GAIN  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_BIAS  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BIAS_OFFSET = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_NORM = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TONE_COEFF  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_WET_MIX     = 3'd6;

    // Q1.16 unity
    localparam logic [16:0] Q16_ONE = 17'h10000;

    // Reset values
    localparam logic        RST_ENABLE      = 1'b0;
    localparam logic [15:0] RST_DRIVE_GAIN  = 16'd4096;
    localparam logic [15:0] RST_DRIVE_BIAS  = 16'd0;
    localparam logic [15:0] RST_BIAS_OFFSET = 16'd0;
    localparam logic [14:0] RST_OUTPUT_NORM = 15'd16384;
    localparam logic [16:0] RST_TONE_COEFF  = 17'd65536;
    localparam logic [16:0] RST_WET_MIX     = 17'd65536;

    typedef struct packed {
        logic        enable;
        logic [15:0] drive_gain;
        logic [15:0] drive_bias;
        logic [15:0] bias_offset;
        logic [14:0] output_norm;
        logic [16:0] tone_coeff;
        logic [16:0] wet_mix;
    } tow_cfg_t;

    // One step of the sample sequence
    typedef struct packed {
        logic load;      // capture the input beat
        logic gain;      // scale and bias
        logic pos;       // magnitude, table index and fraction
        logic rom_next;  // address the upper table point
        logic rom0_cap;  // hold the lower table point
        logic interp;    // interpolate and restore sign
        logic norm;      // remove bias offset and normalize
        logic tone;      // one-pole lowpass
        logic mix;       // dry/wet blend
        logic out_load;  // move result to the output register
    } tow_cmd_t;

    typedef struct packed {
        logic enable;
        logic tone_active;
    } tow_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tow_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tanh overdrive stream interfaces
// Valid/ready sample channels for the input and the output side.
// ----------------------------------------------------------------------------
interface tow_in_if
    import tow_pkg::*;
#(
    parameter int SAMPLE_WIDTH = TOW_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface tow_out_if
    import tow_pkg::*;
#(
    parameter int SAMPLE_WIDTH = TOW_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/tanh_overdrive_waveshaper.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tanh overdrive waveshaper
// Soft-clip overdrive on a stream of signed Q1.F audio samples.
// ----------------------------------------------------------------------------
// One sample in gives one sample out, in order. With enable low a sample
// passes unchanged, going from the load step straight to the output step.
// With enable high a sample is scaled by drive_gain, offset by drive_bias,
// shaped by tanh from a table of TANH_TABLE_SIZE+1 points over [0,8] with
// linear interpolation (saturating beyond 8), has bias_offset removed, is
// scaled by output_norm, optionally runs through a one-pole lowpass (when
// tone_coeff is below 1.0) and is blended with the dry sample by wet_mix,
// saturating to the sample range. An active lowpass adds a tone step. The
// controller walks one step a cycle unless held by the output register;
// the table has a single registered read port, so the two interpolation
// points take two reads. The result sits in an output register, so the next
// sample is accepted while a result still waits to be taken; the sequence
// holds in its last step only while that register is full. The table is a
// constant built at elaboration; there is no clearing pass after reset.
// Write configuration only while no sample is in flight.
// ----------------------------------------------------------------------------
module tanh_overdrive_waveshaper
    import tow_pkg::*;
#(
    parameter int SAMPLE_WIDTH    = TOW_SAMPLE_WIDTH,
    parameter int TANH_TABLE_SIZE = TOW_TANH_TABLE_SIZE
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    tow_in_if.sink                 in_ch,
    tow_out_if.source              out_ch
);

    tow_cfg_t    cfg;
    tow_cmd_t    cmd;
    tow_status_t status;
    logic        in_ready;
    logic        out_valid;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;

    // Register file: to be written only while idle, which it does not enforce itself
    tow_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer: one datapath step per cycle unless holding for the output register, owns both handshakes
    tow_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic, tanh table, tone state and output register
    tow_datapath #(
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .TANH_TABLE_SIZE (TANH_TABLE_SIZE)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .sample_in  (in_ch.sample_in),
        .sample_out (sample_out),
        .status     (status)
    );

    assign in_ch.ready       = in_ready;
    assign out_ch.valid      = out_valid;
    assign out_ch.sample_out = sample_out;

`ifndef ASSERT_OFF
    // An accepted beat starts a sequence, so the input closes right after
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready
    ) else $error("input stayed open after an accepted beat");

    // Never overwrite a result that has not been taken
    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_ch.valid || out_ch.ready)
    ) else $error("output register loaded while holding an untaken beat");

    // At most one datapath step per cycle, the table read commands apart
    a_one_step: assert property (
        @(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.gain, cmd.pos, cmd.interp, cmd.norm,
                  cmd.tone, cmd.mix, cmd.out_load})
    ) else $error("more than one datapath step issued");

    // Advance the lowpass state only when shaping with the filter active
    a_tone_gate: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.tone |-> (status.enable && status.tone_active)
    ) else $error("tone state advanced while bypassed");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/tow_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tanh overdrive configuration registers
// Write-only register file for the shaper coefficients.
// ----------------------------------------------------------------------------
module tow_cfg_regs
    import tow_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output tow_cfg_t               cfg
);

    tow_cfg_t cfg_reg;
    tow_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENABLE:      cfg_next.enable      = cfg_data[0];
                REG_DRIVE_GAIN:  cfg_next.drive_gain  = cfg_data[15:0];
                REG_DRIVE_BIAS:  cfg_next.drive_bias  = cfg_data[15:0];
                REG_BIAS_OFFSET: cfg_next.bias_offset = cfg_data[15:0];
                REG_OUTPUT_NORM: cfg_next.output_norm = cfg_data[14:0];
                REG_TONE_COEFF:  cfg_next.tone_coeff  = cfg_data[16:0];
                REG_WET_MIX:     cfg_next.wet_mix     = cfg_data[16:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable      <= RST_ENABLE;
            cfg_reg.drive_gain  <= RST_DRIVE_GAIN;
            cfg_reg.drive_bias  <= RST_DRIVE_BIAS;
            cfg_reg.bias_offset <= RST_BIAS_OFFSET;
            cfg_reg.output_norm <= RST_OUTPUT_NORM;
            cfg_reg.tone_coeff  <= RST_TONE_COEFF;
            cfg_reg.wet_mix     <= RST_WET_MIX;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/tow_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tanh overdrive controller
// Sequences one sample through the datapath and owns the stream handshakes.
// ----------------------------------------------------------------------------
module tow_ctrl
    import tow_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  tow_status_t status,
    output tow_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_GAIN   = 4'd1;
    localparam logic [3:0] S_POS    = 4'd2;
    localparam logic [3:0] S_ROM0   = 4'd3;
    localparam logic [3:0] S_ROM1   = 4'd4;
    localparam logic [3:0] S_INTERP = 4'd5;
    localparam logic [3:0] S_NORM   = 4'd6;
    localparam logic [3:0] S_TONE   = 4'd7;
    localparam logic [3:0] S_MIX    = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.enable ? S_GAIN : S_OUT;
                end
            end
            S_GAIN:
            begin
                cmd.gain   = 1'b1;
                state_next = S_POS;
            end
            S_POS:
            begin
                cmd.pos    = 1'b1;
                state_next = S_ROM0;
            end
            S_ROM0:
            begin
                state_next = S_ROM1;
            end
            S_ROM1:
            begin
                cmd.rom_next = 1'b1;
                cmd.rom0_cap = 1'b1;
                state_next   = S_INTERP;
            end
            S_INTERP:
            begin
                cmd.interp = 1'b1;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                cmd.norm   = 1'b1;
                state_next = status.tone_active ? S_TONE : S_MIX;
            end
            S_TONE:
            begin
                cmd.tone   = 1'b1;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                cmd.mix    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register can take the beat
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/tow_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tanh overdrive datapath
// Gain, tanh table lookup with interpolation, normalization, tone and mix.
// ----------------------------------------------------------------------------
module tow_datapath
    import tow_pkg::*;
#(
    parameter int SAMPLE_WIDTH    = TOW_SAMPLE_WIDTH,
    parameter int TANH_TABLE_SIZE = TOW_TANH_TABLE_SIZE
)(
    input  logic                           clk,
    input  logic                           rst_n,
    input  tow_cfg_t                       cfg,
    input  tow_cmd_t                       cmd,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    output tow_status_t                    status
);

    localparam int F   = SAMPLE_WIDTH - 2;            // fraction bits
    localparam int AW  = SAMPLE_WIDTH + 6;            // shaper argument
    localparam int XB  = $clog2(TANH_TABLE_SIZE);     // segment index
    localparam int AB  = $clog2(TANH_TABLE_SIZE + 1); // table address
    localparam int PW  = F + 3 + XB;                  // scaled position
    localparam int RW  = F + 1;                       // table entry
    localparam int TW  = F + 3;                       // signed tanh
    localparam int YW  = SAMPLE_WIDTH + 3;            // shaped sample
    localparam int SW8 = SAMPLE_WIDTH + 8;            // pre-saturation sums

    typedef logic [TANH_TABLE_SIZE:0][RW-1:0] rom_t;

    // (a * b) >> 60, truncated to 64 bits
    function automatic longint unsigned mul_q60(longint unsigned a, longint unsigned b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // Long division by shift and subtract, for the table build only
    function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
        longint unsigned q;
        logic [64:0]     rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d})
            begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(8 i / N) in Q.F from q = exp(-16/N) built in Q60
    function automatic rom_t build_rom();
        rom_t            rom;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned base;
        longint unsigned pw;
        longint unsigned num;
        longint unsigned den;
        int              sh;
        rom  = '0;
        term = 64'd1 << 59;
        sum  = 64'd1 << 59;
        sh   = F - 2;
        for (int k = 1; k <= 24; k++)
        begin
            term = udiv64(term * 64'd16, 64'(TANH_TABLE_SIZE) * 64'(k));
            if ((k & 1) != 0)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        base = sum << 1;
        pw   = 64'd1 << 60;
        for (int i = 0; i <= TANH_TABLE_SIZE; i++)
        begin
            num    = ((64'd1 << 60) - pw) >> sh;
            den    = ((64'd1 << 60) + pw) >> sh;
            rom[i] = RW'(udiv64((num << F) + (den >> 1), den));
            pw     = mul_q60(pw, base);
        end
        return rom;
    endfunction

    localparam rom_t TANH_ROM = build_rom();

    // Q0.16 to Q.F with a floor shift
    function automatic logic [F-1:0] align_q16(logic [15:0] v);
        logic [F+15:0] w;
        w = {v, {F{1'b0}}};
        return w[F+15:16];
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(logic signed [SW8-1:0] v);
        logic signed [SAMPLE_WIDTH-1:0] r;
        if (v[SW8-1:SAMPLE_WIDTH-1] == {(SW8-SAMPLE_WIDTH+1){v[SW8-1]}})
        begin
            r = v[SAMPLE_WIDTH-1:0];
        end
        else if (v[SW8-1])
        begin
            r = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
        return r;
    endfunction

    // Registers
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] res_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_data_reg;
    logic signed [SAMPLE_WIDTH-1:0] tone_reg;
    logic signed [AW-1:0]           a_reg;
    logic                           sign_reg;
    logic                           sat_reg;
    logic [XB-1:0]                  idx_reg;
    logic [F-1:0]                   fr_reg;
    logic [RW-1:0]                  rom_data_reg;
    logic [RW-1:0]                  rom0_reg;
    logic signed [TW-1:0]           t_reg;
    logic signed [YW-1:0]           y_reg;

    // Gain and bias
    logic signed [SAMPLE_WIDTH+16:0] gain_prod;
    logic signed [AW-1:0]            gain_term;
    logic signed [AW-1:0]            bias_term;
    logic signed [AW-1:0]            a_next;

    // Position
    logic [AW-1:0] mag;
    logic [PW-1:0] pos;
    logic          sat_next;
    logic [AB-1:0] rom_addr;

    // Interpolation
    logic signed [F+1:0]   rom_diff;
    logic signed [2*F+2:0] interp_prod;
    logic signed [TW-1:0]  interp_base;
    logic signed [TW-1:0]  t_mag;
    logic signed [TW-1:0]  t_next;

    // Normalization
    logic signed [TW:0]    shaped_diff;
    logic signed [TW+16:0] norm_prod;
    logic signed [YW-1:0]  y_norm;

    // Tone filter
    logic signed [YW:0]             tone_err;
    logic signed [YW+17:0]          tone_prod;
    logic signed [SW8-1:0]          tone_sum;
    logic signed [SAMPLE_WIDTH-1:0] tone_next;

    // Dry/wet mix
    logic [16:0]                    mix_gain;
    logic signed [YW:0]             mix_err;
    logic signed [YW+18:0]          mix_prod;
    logic signed [SW8-1:0]          mix_sum;
    logic signed [SAMPLE_WIDTH-1:0] mix_next;

    always_comb
    begin
        gain_prod = x_reg * $signed({1'b0, cfg.drive_gain});
        gain_term = AW'(gain_prod >>> 12);
        bias_term = AW'({1'b0, align_q16(cfg.drive_bias)});
        a_next    = gain_term + bias_term;

        mag      = a_reg[AW-1] ? -a_reg : a_reg;
        sat_next = |mag[AW-2:F+3];
        pos      = PW'(mag[F+2:0]) * PW'(TANH_TABLE_SIZE);

        if (sat_reg)
        begin
            rom_addr = AB'(TANH_TABLE_SIZE);
        end
        else if (cmd.rom_next)
        begin
            rom_addr = AB'(idx_reg) + AB'(1);
        end
        else
        begin
            rom_addr = AB'(idx_reg);
        end

        rom_diff    = $signed({1'b0, rom_data_reg}) - $signed({1'b0, rom0_reg});
        interp_prod = rom_diff * $signed({1'b0, fr_reg});
        interp_base = TW'({1'b0, rom0_reg});
        t_mag       = sat_reg ? interp_base : interp_base + TW'(interp_prod >>> F);
        t_next      = sign_reg ? -t_mag : t_mag;

        shaped_diff = (TW+1)'(t_reg) - $signed((TW+1)'({1'b0, align_q16(cfg.bias_offset)}));
        norm_prod   = shaped_diff * $signed({1'b0, cfg.output_norm});
        y_norm      = YW'(norm_prod >>> 14);

        tone_err  = (YW+1)'(y_reg) - (YW+1)'(tone_reg);
        tone_prod = tone_err * $signed({1'b0, cfg.tone_coeff[15:0]});
        tone_sum  = SW8'(tone_reg) + SW8'(tone_prod >>> 16);
        tone_next = sat_sample(tone_sum);

        mix_gain = (cfg.wet_mix > Q16_ONE) ? Q16_ONE : cfg.wet_mix;
        mix_err  = (YW+1)'(y_reg) - (YW+1)'(x_reg);
        mix_prod = mix_err * $signed({1'b0, mix_gain});
        mix_sum  = SW8'(x_reg) + SW8'(mix_prod >>> 16);
        mix_next = sat_sample(mix_sum);
    end

    // Table read port, one address a cycle
    always_ff @(posedge clk)
    begin
        rom_data_reg <= TANH_ROM[rom_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg   <= sample_in;
            res_reg <= sample_in;
        end
        if (cmd.gain)
        begin
            a_reg <= a_next;
        end
        if (cmd.pos)
        begin
            sign_reg <= a_reg[AW-1];
            sat_reg  <= sat_next;
            idx_reg  <= pos[PW-1:F+3];
            fr_reg   <= pos[F+2:3];
        end
        if (cmd.rom0_cap)
        begin
            rom0_reg <= rom_data_reg;
        end
        if (cmd.interp)
        begin
            t_reg <= t_next;
        end
        if (cmd.norm)
        begin
            y_reg <= y_norm;
        end
        else if (cmd.tone)
        begin
            y_reg <= YW'(tone_next);
        end
        if (cmd.mix)
        begin
            res_reg <= mix_next;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_reg <= '0;
        end
        else if (cmd.tone)
        begin
            tone_reg <= tone_next;
        end
    end

    assign sample_out         = out_data_reg;
    assign status.enable      = cfg.enable;
    assign status.tone_active = !cfg.tone_coeff[16];

endmodule
`default_nettype wire
